// File: src/bgc_pkg.sv
package bgc_pkg;

    localparam int WAIT_BITS_DEFAULT = 18;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 18;

    localparam logic [CFG_INDEX_W-1:0] CFG_STEP_TICKS   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_OPEN_ANGLE   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_CLEAR_WAIT   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_AUTH_TIMEOUT = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_REFUSE_HOLD  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_BLINK_TICKS  = 3'd5;

    localparam logic [7:0]  STEP_TICKS_RST   = 8'd20;
    localparam logic [7:0]  OPEN_ANGLE_RST   = 8'd90;
    localparam logic [15:0] CLEAR_WAIT_RST   = 16'd5000;
    localparam logic [17:0] AUTH_TIMEOUT_RST = 18'd120000;
    localparam logic [15:0] REFUSE_HOLD_RST  = 16'd3000;
    localparam logic [9:0]  BLINK_TICKS_RST  = 10'd300;

    localparam logic [7:0] MAX_ANGLE = 8'd180;

    localparam int AUTH_BLINK_PERIOD = 500;
    localparam int AUTH_BLINK_ON     = 250;
    localparam int AUTH_MOD_W        = $clog2(AUTH_BLINK_PERIOD);

    typedef struct packed {
        logic [7:0]  step_ticks;
        logic [7:0]  open_angle;
        logic [15:0] clear_wait_ticks;
        logic [17:0] auth_timeout_ticks;
        logic [15:0] refuse_hold_ticks;
        logic [9:0]  blink_ticks;
    } cfg_t;

    typedef enum logic [7:0] {
        PH_IDLE    = 8'b0000_0001,
        PH_AUTH    = 8'b0000_0010,
        PH_REFUSED = 8'b0000_0100,
        PH_OPENING = 8'b0000_1000,
        PH_OPEN    = 8'b0001_0000,
        PH_SAFETY  = 8'b0010_0000,
        PH_CLOSING = 8'b0100_0000,
        PH_RERAISE = 8'b1000_0000
    } phase_t;

    localparam logic [2:0] CODE_IDLE    = 3'd0;
    localparam logic [2:0] CODE_AUTH    = 3'd1;
    localparam logic [2:0] CODE_REFUSED = 3'd2;
    localparam logic [2:0] CODE_OPENING = 3'd3;
    localparam logic [2:0] CODE_OPEN    = 3'd4;
    localparam logic [2:0] CODE_SAFETY  = 3'd5;
    localparam logic [2:0] CODE_CLOSING = 3'd6;
    localparam logic [2:0] CODE_RERAISE = 3'd7;

    localparam logic [2:0] REP_NONE    = 3'd0;
    localparam logic [2:0] REP_CLOSED  = 3'd1;
    localparam logic [2:0] REP_OPENING = 3'd2;
    localparam logic [2:0] REP_OPEN    = 3'd3;
    localparam logic [2:0] REP_SAFETY  = 3'd4;
    localparam logic [2:0] REP_CLOSING = 3'd5;

    localparam logic [2:0] LED_OFF    = 3'd0;
    localparam logic [2:0] LED_GREEN  = 3'd1;
    localparam logic [2:0] LED_RED    = 3'd2;
    localparam logic [2:0] LED_YELLOW = 3'd3;
    localparam logic [2:0] LED_BLUE   = 3'd4;

    localparam logic [1:0] AUTH_NONE   = 2'd0;
    localparam logic [1:0] AUTH_GRANT  = 2'd1;
    localparam logic [1:0] AUTH_REJECT = 2'd2;

    typedef struct packed {
        logic [2:0] gate_phase;
        logic [7:0] servo_angle;
        logic [2:0] led_color;
        logic       travel_exit;
        logic       auth_wanted;
        logic [2:0] status_report;
        logic       last_of_run;
    } result_t;

    function automatic logic [2:0] phase_code(input phase_t ph);
        logic [2:0] code;
        case (ph)
            PH_IDLE:    code = CODE_IDLE;
            PH_AUTH:    code = CODE_AUTH;
            PH_REFUSED: code = CODE_REFUSED;
            PH_OPENING: code = CODE_OPENING;
            PH_OPEN:    code = CODE_OPEN;
            PH_SAFETY:  code = CODE_SAFETY;
            PH_CLOSING: code = CODE_CLOSING;
            PH_RERAISE: code = CODE_RERAISE;
            default:    code = CODE_IDLE;
        endcase
        return code;
    endfunction

endpackage

// File: src/bgc_cfg_regs.sv
module bgc_cfg_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    input  logic [bgc_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [bgc_pkg::CFG_DATA_W-1:0]    cfg_data,
    output logic                              cfg_ready,
    output bgc_pkg::cfg_t                     cfg
);
    import bgc_pkg::*;

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.step_ticks         <= STEP_TICKS_RST;
            cfg_reg.open_angle         <= OPEN_ANGLE_RST;
            cfg_reg.clear_wait_ticks   <= CLEAR_WAIT_RST;
            cfg_reg.auth_timeout_ticks <= AUTH_TIMEOUT_RST;
            cfg_reg.refuse_hold_ticks  <= REFUSE_HOLD_RST;
            cfg_reg.blink_ticks        <= BLINK_TICKS_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_STEP_TICKS:   cfg_reg.step_ticks         <= cfg_data[7:0];
                CFG_OPEN_ANGLE:   cfg_reg.open_angle         <= cfg_data[7:0];
                CFG_CLEAR_WAIT:   cfg_reg.clear_wait_ticks   <= cfg_data[15:0];
                CFG_AUTH_TIMEOUT: cfg_reg.auth_timeout_ticks <= cfg_data[17:0];
                CFG_REFUSE_HOLD:  cfg_reg.refuse_hold_ticks  <= cfg_data[15:0];
                CFG_BLINK_TICKS:  cfg_reg.blink_ticks        <= cfg_data[9:0];
                default:          ;
            endcase
        end
    end

endmodule

// File: src/bgc_core.sv
module bgc_core #(
    parameter int WAIT_BITS = bgc_pkg::WAIT_BITS_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             tick,
    input  logic             outer_beam_blocked,
    input  logic             inner_beam_blocked,
    input  logic [1:0]       auth_event,
    input  bgc_pkg::cfg_t    cfg,
    output bgc_pkg::result_t res0,
    output bgc_pkg::result_t res1,
    output logic             two_res
);
    import bgc_pkg::*;

    localparam int CMP_W = (WAIT_BITS > 18) ? WAIT_BITS : 18;
    localparam logic [WAIT_BITS-1:0] WAIT_MAX = {WAIT_BITS{1'b1}};
    localparam logic [AUTH_MOD_W-1:0] MOD_LAST = AUTH_MOD_W'(AUTH_BLINK_PERIOD - 1);
    localparam logic [AUTH_MOD_W-1:0] MOD_ON   = AUTH_MOD_W'(AUTH_BLINK_ON);

    phase_t                 phase_reg, phase_next;
    logic                   exit_reg, exit_next;
    logic [7:0]             angle_reg, angle_next;
    logic [7:0]             step_reg, step_next;
    logic [WAIT_BITS-1:0]   wait_reg, wait_next;
    logic [AUTH_MOD_W-1:0]  mod_reg, mod_next;
    logic                   car_reg, car_next;
    logic [9:0]             blink_reg, blink_next;
    logic                   lit_reg, lit_next;

    logic                   start_blk, final_blk;
    logic [7:0]             step_inc, top_angle, raise_angle;
    logic                   step_due, raise_done;
    logic [9:0]             blink_inc;
    logic                   blink_wrap;
    logic [WAIT_BITS-1:0]   wait_bump;
    logic [AUTH_MOD_W-1:0]  mod_bump;
    logic [CMP_W-1:0]       wait_bump_x;
    logic [2:0]             rep0, rep1;
    logic                   rep_two;
    logic [2:0]             led;

    assign start_blk = exit_reg ? inner_beam_blocked : outer_beam_blocked;
    assign final_blk = exit_reg ? outer_beam_blocked : inner_beam_blocked;

    assign step_inc = step_reg + 8'd1;
    assign step_due = (step_inc >= cfg.step_ticks) || (step_inc == 8'd0);

    assign blink_inc  = blink_reg + 10'd1;
    assign blink_wrap = (blink_inc >= cfg.blink_ticks) || (blink_inc == 10'd0);

    assign top_angle   = (cfg.open_angle > MAX_ANGLE) ? MAX_ANGLE : cfg.open_angle;
    assign raise_done  = ((angle_reg < top_angle) ? (angle_reg + 8'd1) : angle_reg)
                         >= top_angle;
    assign raise_angle = raise_done ? top_angle : (angle_reg + 8'd1);

    assign wait_bump   = (wait_reg == WAIT_MAX) ? wait_reg : (wait_reg + 1'b1);
    assign mod_bump    = (wait_reg == WAIT_MAX) ? mod_reg
                       : ((mod_reg == MOD_LAST) ? '0 : (mod_reg + 1'b1));
    assign wait_bump_x = CMP_W'(wait_bump);

    always_comb
    begin
        phase_next = phase_reg;
        exit_next  = exit_reg;
        angle_next = angle_reg;
        step_next  = step_reg;
        wait_next  = wait_reg;
        mod_next   = mod_reg;
        car_next   = car_reg;
        blink_next = blink_reg;
        lit_next   = lit_reg;
        rep0       = REP_NONE;
        rep1       = REP_NONE;
        rep_two    = 1'b0;

        case (phase_reg)
            PH_IDLE:
            begin
                if (outer_beam_blocked || inner_beam_blocked)
                begin
                    exit_next  = !outer_beam_blocked;
                    phase_next = PH_AUTH;
                    wait_next  = '0;
                    mod_next   = '0;
                end
            end
            PH_AUTH:
            begin
                if (auth_event == AUTH_GRANT)
                begin
                    phase_next = PH_OPENING;
                    angle_next = 8'd0;
                    step_next  = 8'd0;
                    car_next   = 1'b0;
                    rep0       = REP_OPENING;
                end
                else if (auth_event == AUTH_REJECT)
                begin
                    phase_next = PH_REFUSED;
                    wait_next  = '0;
                    mod_next   = '0;
                    rep0       = REP_CLOSED;
                end
                else if (wait_bump_x >= CMP_W'(cfg.auth_timeout_ticks))
                begin
                    phase_next = PH_REFUSED;
                    wait_next  = '0;
                    mod_next   = '0;
                    rep0       = REP_CLOSED;
                end
                else
                begin
                    wait_next = wait_bump;
                    mod_next  = mod_bump;
                end
            end
            PH_REFUSED:
            begin
                if (wait_bump_x >= CMP_W'(cfg.refuse_hold_ticks))
                begin
                    phase_next = PH_IDLE;
                    wait_next  = '0;
                    mod_next   = '0;
                end
                else
                begin
                    wait_next = wait_bump;
                    mod_next  = mod_bump;
                end
            end
            PH_OPENING:
            begin
                if (!car_reg)
                begin
                    blink_next = blink_wrap ? 10'd0 : blink_inc;
                    lit_next   = lit_reg ^ blink_wrap;
                end
                step_next = step_due ? 8'd0 : step_inc;
                if (step_due)
                begin
                    angle_next = raise_angle;
                    car_next   = car_reg | final_blk;
                    if (raise_done)
                    begin
                        rep0 = REP_OPEN;
                        if (car_reg || final_blk)
                        begin
                            rep1       = REP_SAFETY;
                            rep_two    = 1'b1;
                            phase_next = PH_SAFETY;
                            wait_next  = '0;
                            mod_next   = '0;
                        end
                        else
                        begin
                            phase_next = PH_OPEN;
                        end
                    end
                end
            end
            PH_OPEN:
            begin
                if (final_blk)
                begin
                    phase_next = PH_SAFETY;
                    wait_next  = '0;
                    mod_next   = '0;
                    rep0       = REP_SAFETY;
                end
            end
            PH_SAFETY:
            begin
                if (start_blk)
                begin
                    phase_next = PH_OPEN;
                    wait_next  = '0;
                    mod_next   = '0;
                    rep0       = REP_OPEN;
                end
                else if ((wait_reg != '0) || !final_blk)
                begin
                    if (wait_bump_x >= CMP_W'(cfg.clear_wait_ticks))
                    begin
                        phase_next = PH_CLOSING;
                        wait_next  = '0;
                        mod_next   = '0;
                        step_next  = 8'd0;
                        rep0       = REP_CLOSING;
                    end
                    else
                    begin
                        wait_next = wait_bump;
                        mod_next  = mod_bump;
                    end
                end
            end
            PH_CLOSING:
            begin
                step_next = step_due ? 8'd0 : step_inc;
                if (step_due)
                begin
                    if (start_blk)
                    begin
                        phase_next = PH_RERAISE;
                    end
                    else if (angle_reg <= 8'd1)
                    begin
                        angle_next = 8'd0;
                        phase_next = PH_IDLE;
                        wait_next  = '0;
                        mod_next   = '0;
                        rep0       = REP_CLOSED;
                    end
                    else
                    begin
                        angle_next = angle_reg - 8'd1;
                    end
                end
            end
            PH_RERAISE:
            begin
                blink_next = blink_wrap ? 10'd0 : blink_inc;
                lit_next   = lit_reg ^ blink_wrap;
                step_next  = step_due ? 8'd0 : step_inc;
                if (step_due)
                begin
                    angle_next = raise_angle;
                    if (raise_done)
                    begin
                        phase_next = PH_OPEN;
                        wait_next  = '0;
                        mod_next   = '0;
                        rep0       = REP_OPEN;
                    end
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_comb
    begin
        case (phase_next)
            PH_IDLE:    led = LED_RED;
            PH_AUTH:    led = (mod_next < MOD_ON) ? LED_YELLOW : LED_OFF;
            PH_REFUSED: led = LED_RED;
            PH_OPEN:    led = LED_GREEN;
            PH_SAFETY:  led = LED_BLUE;
            PH_CLOSING: led = LED_BLUE;
            PH_OPENING: led = lit_next ? LED_GREEN : LED_OFF;
            PH_RERAISE: led = lit_next ? LED_GREEN : LED_OFF;
            default:    led = LED_RED;
        endcase
    end

    always_comb
    begin
        res0.gate_phase    = phase_code(phase_next);
        res0.servo_angle   = angle_next;
        res0.led_color     = led;
        res0.travel_exit   = exit_next;
        res0.auth_wanted   = (phase_next == PH_AUTH);
        res0.status_report = rep0;
        res0.last_of_run   = !rep_two;
        res1               = res0;
        res1.status_report = rep1;
        res1.last_of_run   = 1'b1;
    end

    assign two_res = rep_two;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            exit_reg  <= 1'b0;
            angle_reg <= 8'd0;
            step_reg  <= 8'd0;
            wait_reg  <= '0;
            mod_reg   <= '0;
            car_reg   <= 1'b0;
            blink_reg <= 10'd0;
            lit_reg   <= 1'b0;
        end
        else if (tick)
        begin
            phase_reg <= phase_next;
            exit_reg  <= exit_next;
            angle_reg <= angle_next;
            step_reg  <= step_next;
            wait_reg  <= wait_next;
            mod_reg   <= mod_next;
            car_reg   <= car_next;
            blink_reg <= blink_next;
            lit_reg   <= lit_next;
        end
    end

    a_angle_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        angle_reg <= MAX_ANGLE)
        else $error("servo angle beyond travel");

    a_two_only_at_raise_end: assert property (@(posedge clk) disable iff (!rst_n)
        (tick && two_res) |-> (phase_reg == PH_OPENING && rep0 == REP_OPEN
                               && rep1 == REP_SAFETY))
        else $error("double report outside opening end");

    a_auth_clears_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (tick && phase_reg == PH_IDLE && phase_next == PH_AUTH)
        |=> (wait_reg == '0 && mod_reg == '0))
        else $error("auth wait did not start from zero");

endmodule

// File: src/bgc_out_queue.sv
module bgc_out_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic             push_two,
    input  bgc_pkg::result_t wr0,
    input  bgc_pkg::result_t wr1,
    output logic             has_room,
    output logic             out_valid,
    input  logic             out_stall,
    output bgc_pkg::result_t rd
);
    import bgc_pkg::*;

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = PTR_W + 1;

    result_t            entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [PTR_W-1:0]   wr_ptr_1;
    logic               pop;
    logic [CNT_W-1:0]   push_n;

    assign has_room  = count_reg <= CNT_W'(DEPTH - 2);
    assign out_valid = count_reg != '0;
    assign rd        = entry_reg[rd_ptr_reg];
    assign pop       = out_valid && !out_stall;
    assign wr_ptr_1  = wr_ptr_reg + 1'b1;

    assign push_n      = push ? (push_two ? CNT_W'(2) : CNT_W'(1)) : '0;
    assign wr_ptr_next = wr_ptr_reg + push_n[PTR_W-1:0];
    assign rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
    assign count_next  = count_reg + push_n - CNT_W'(pop);

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wr0;
            if (push_two)
            begin
                entry_reg[wr_ptr_1] <= wr1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("result queue overflow");

    a_push_with_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> has_room)
        else $error("push into full result queue");

    a_ptr_count_agree: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0 || count_reg == CNT_W'(DEPTH)) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with count");

endmodule

// File: src/barrier_gate_controller.sv
// Channel   Handshake              Carries
// ticks     in_valid / in_stall    outer_beam_blocked, inner_beam_blocked, auth_event
// results   out_valid / out_stall  gate_phase, servo_angle, led_color, travel_exit,
//                                  auth_wanted, status_report, last_of_run
// config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One tick is taken per clock while in_stall is low; its results are written to a
// four-entry result queue on the same edge and leave it in order from its head.
// A tick yields one result, or two when an opening ends with the car already seen.
// in_stall rises while fewer than two queue entries are free; it depends on
// registered state only. No clearing pass after reset; config is always ready.
module barrier_gate_controller #(
    parameter int WAIT_BITS = bgc_pkg::WAIT_BITS_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             outer_beam_blocked,
    input  logic                             inner_beam_blocked,
    input  logic [1:0]                       auth_event,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [2:0]                       gate_phase,
    output logic [7:0]                       servo_angle,
    output logic [2:0]                       led_color,
    output logic                             travel_exit,
    output logic                             auth_wanted,
    output logic [2:0]                       status_report,
    output logic                             last_of_run,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [bgc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [bgc_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import bgc_pkg::*;

    cfg_t    cfg;
    result_t res0, res1, rd;
    logic    two_res;
    logic    has_room;
    logic    tick;

    assign in_stall = !has_room;
    assign tick     = in_valid && has_room;

    bgc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg_ready (cfg_ready),
        .cfg       (cfg)
    );

    bgc_core #(
        .WAIT_BITS (WAIT_BITS)
    ) u_core (
        .clk                (clk),
        .rst_n              (rst_n),
        .tick               (tick),
        .outer_beam_blocked (outer_beam_blocked),
        .inner_beam_blocked (inner_beam_blocked),
        .auth_event         (auth_event),
        .cfg                (cfg),
        .res0               (res0),
        .res1               (res1),
        .two_res            (two_res)
    );

    bgc_out_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (tick),
        .push_two  (two_res),
        .wr0       (res0),
        .wr1       (res1),
        .has_room  (has_room),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .rd        (rd)
    );

    assign gate_phase    = rd.gate_phase;
    assign servo_angle   = rd.servo_angle;
    assign led_color     = rd.led_color;
    assign travel_exit   = rd.travel_exit;
    assign auth_wanted   = rd.auth_wanted;
    assign status_report = rd.status_report;
    assign last_of_run   = rd.last_of_run;

endmodule

// File: tb/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bgc_pkg::*;

    localparam logic [1:0]             AUTH_UNUSED  = 2'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_NO_REG_6 = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] CFG_NO_REG_7 = 3'd7;
    localparam int                     WAIT_W       = WAIT_BITS_DEFAULT;

    typedef enum int {
        SET_SMALL,
        SET_MAXED,
        SET_WIDE,
        SET_MINIMAL,
        SET_ONES
    } cfg_profile_t;

    typedef struct {
        bit                     is_cfg;
        logic [CFG_INDEX_W-1:0] idx;
        logic [CFG_DATA_W-1:0]  data;
        bit                     outer;
        bit                     inner;
        logic [1:0]             ev;
        bit                     typed;
        result_t                want;
    } step_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic                   outer_beam_blocked = 1'b0;
    logic                   inner_beam_blocked = 1'b0;
    logic [1:0]             auth_event = AUTH_NONE;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [2:0]             gate_phase;
    logic [7:0]             servo_angle;
    logic [2:0]             led_color;
    logic                   travel_exit;
    logic                   auth_wanted;
    logic [2:0]             status_report;
    logic                   last_of_run;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = CFG_STEP_TICKS;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // gate state as the block should hold it
    logic [2:0]        gs_phase = CODE_IDLE;
    bit                gs_exit = 1'b0;
    logic [7:0]        gs_angle = '0;
    logic [7:0]        gs_step = '0;
    logic [WAIT_W-1:0] gs_wait = '0;
    bit                gs_car = 1'b0;
    logic [9:0]        gs_blink = '0;
    bit                gs_lit = 1'b0;

    logic [7:0]  gc_step = STEP_TICKS_RST;
    logic [7:0]  gc_angle = OPEN_ANGLE_RST;
    logic [15:0] gc_clear = CLEAR_WAIT_RST;
    logic [17:0] gc_timeout = AUTH_TIMEOUT_RST;
    logic [15:0] gc_refuse = REFUSE_HOLD_RST;
    logic [9:0]  gc_blink = BLINK_TICKS_RST;

    result_t gate_snapshots[$];
    int      fail_count = 0;
    bit      tx_gaps = 1'b1;
    bit      rx_gaps = 1'b1;
    int      rx_hold = 0;

    barrier_gate_controller u_top (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .outer_beam_blocked (outer_beam_blocked),
        .inner_beam_blocked (inner_beam_blocked),
        .auth_event         (auth_event),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .gate_phase         (gate_phase),
        .servo_angle        (servo_angle),
        .led_color          (led_color),
        .travel_exit        (travel_exit),
        .auth_wanted        (auth_wanted),
        .status_report      (status_report),
        .last_of_run        (last_of_run),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial
    begin
        #3_000_000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic bit step_due();
        gs_step = gs_step + 8'd1;
        if (gs_step >= gc_step || gs_step == 8'd0)
        begin
            gs_step = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void blink_advance();
        gs_blink = gs_blink + 10'd1;
        if (gs_blink >= gc_blink || gs_blink == 10'd0)
        begin
            gs_blink = '0;
            gs_lit = !gs_lit;
        end
    endfunction

    function automatic void wait_advance();
        if (gs_wait != '1)
            gs_wait = gs_wait + 1'b1;
    endfunction

    function automatic bit raise_arm();
        logic [7:0] top;
        top = (gc_angle > MAX_ANGLE) ? MAX_ANGLE : gc_angle;
        if (gs_angle < top)
            gs_angle = gs_angle + 8'd1;
        if (gs_angle >= top)
        begin
            gs_angle = top;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // advance the gate by one tick and queue the snapshots it should produce
    function automatic void compute_gate_tick(bit o, bit i, logic [1:0] e, bit record);
        bit         st;
        bit         fi;
        logic [2:0] rep [2];
        int         n;
        int         cnt;
        logic [2:0] led;
        result_t    snap;
        bit         done;
        st = gs_exit ? i : o;
        fi = gs_exit ? o : i;
        rep[0] = REP_NONE;
        rep[1] = REP_NONE;
        n = 0;
        case (gs_phase)
            CODE_IDLE:
            begin
                if (o || i)
                begin
                    gs_exit = !o;
                    gs_phase = CODE_AUTH;
                    gs_wait = '0;
                end
            end
            CODE_AUTH:
            begin
                if (e == AUTH_GRANT)
                begin
                    gs_phase = CODE_OPENING;
                    gs_angle = '0;
                    gs_step = '0;
                    gs_car = 1'b0;
                    rep[n++] = REP_OPENING;
                end
                else if (e == AUTH_REJECT)
                begin
                    gs_phase = CODE_REFUSED;
                    gs_wait = '0;
                    rep[n++] = REP_CLOSED;
                end
                else
                begin
                    wait_advance();
                    if (gs_wait >= gc_timeout)
                    begin
                        gs_phase = CODE_REFUSED;
                        gs_wait = '0;
                        rep[n++] = REP_CLOSED;
                    end
                end
            end
            CODE_REFUSED:
            begin
                wait_advance();
                if (gs_wait >= gc_refuse)
                begin
                    gs_phase = CODE_IDLE;
                    gs_wait = '0;
                end
            end
            CODE_OPENING:
            begin
                if (!gs_car)
                    blink_advance();
                if (step_due())
                begin
                    done = raise_arm();
                    if (fi)
                        gs_car = 1'b1;
                    if (done)
                    begin
                        rep[n++] = REP_OPEN;
                        if (gs_car)
                        begin
                            rep[n++] = REP_SAFETY;
                            gs_phase = CODE_SAFETY;
                            gs_wait = '0;
                        end
                        else
                            gs_phase = CODE_OPEN;
                    end
                end
            end
            CODE_OPEN:
            begin
                if (fi)
                begin
                    gs_phase = CODE_SAFETY;
                    gs_wait = '0;
                    rep[n++] = REP_SAFETY;
                end
            end
            CODE_SAFETY:
            begin
                if (st)
                begin
                    gs_phase = CODE_OPEN;
                    gs_wait = '0;
                    rep[n++] = REP_OPEN;
                end
                else if (gs_wait != '0 || !fi)
                begin
                    wait_advance();
                    if (gs_wait >= gc_clear)
                    begin
                        gs_phase = CODE_CLOSING;
                        gs_wait = '0;
                        gs_step = '0;
                        rep[n++] = REP_CLOSING;
                    end
                end
            end
            CODE_CLOSING:
            begin
                if (step_due())
                begin
                    if (st)
                        gs_phase = CODE_RERAISE;
                    else
                    begin
                        if (gs_angle > 8'd0)
                            gs_angle = gs_angle - 8'd1;
                        if (gs_angle == 8'd0)
                        begin
                            gs_phase = CODE_IDLE;
                            gs_wait = '0;
                            rep[n++] = REP_CLOSED;
                        end
                    end
                end
            end
            default:
            begin
                blink_advance();
                if (step_due())
                begin
                    if (raise_arm())
                    begin
                        gs_phase = CODE_OPEN;
                        gs_wait = '0;
                        rep[n++] = REP_OPEN;
                    end
                end
            end
        endcase

        case (gs_phase)
            CODE_IDLE:    led = LED_RED;
            CODE_AUTH:    led = ((gs_wait % AUTH_BLINK_PERIOD) < AUTH_BLINK_ON) ? LED_YELLOW
                                                                             : LED_OFF;
            CODE_REFUSED: led = LED_RED;
            CODE_OPEN:    led = LED_GREEN;
            CODE_SAFETY:  led = LED_BLUE;
            CODE_CLOSING: led = LED_BLUE;
            default:      led = gs_lit ? LED_GREEN : LED_OFF;
        endcase

        cnt = (n == 0) ? 1 : n;
        for (int k = 0; k < cnt; k++)
        begin
            snap.gate_phase    = gs_phase;
            snap.servo_angle   = gs_angle;
            snap.led_color     = led;
            snap.travel_exit   = gs_exit;
            snap.auth_wanted   = (gs_phase == CODE_AUTH);
            snap.status_report = rep[k];
            snap.last_of_run   = (k == cnt - 1);
            if (record)
                gate_snapshots.push_back(snap);
        end
    endfunction

    task automatic send_tick(bit o, bit i, logic [1:0] e, bit typed, result_t want);
        int gap;
        gap = tx_gaps ? $urandom_range(0, 6) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        outer_beam_blocked <= o;
        inner_beam_blocked <= i;
        auth_event <= e;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        compute_gate_tick(o, i, e, !typed);
        if (typed)
            gate_snapshots.push_back(want);
    endtask

    task automatic cfg_write(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        in_valid <= 1'b0;
        while (gate_snapshots.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (cfg_ready !== 1'b1)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_STEP_TICKS:   gc_step = data[7:0];
            CFG_OPEN_ANGLE:   gc_angle = data[7:0];
            CFG_CLEAR_WAIT:   gc_clear = data[15:0];
            CFG_AUTH_TIMEOUT: gc_timeout = data[17:0];
            CFG_REFUSE_HOLD:  gc_refuse = data[15:0];
            CFG_BLINK_TICKS:  gc_blink = data[9:0];
            default:          ;
        endcase
        @(posedge clk);
    endtask

    // bias beams and auth outcomes by phase so that full passages happen often
    task automatic draw_tick(output bit o, output bit i, output logic [1:0] e);
        int st_pct;
        int fi_pct;
        int r;
        bit st;
        bit fi;
        e = 2'($urandom_range(0, 3));
        case (gs_phase)
            CODE_IDLE:
            begin
                st_pct = 15;
                fi_pct = 10;
            end
            CODE_AUTH:
            begin
                st_pct = 5;
                fi_pct = 5;
            end
            CODE_OPENING, CODE_OPEN:
            begin
                st_pct = 10;
                fi_pct = 25;
            end
            CODE_SAFETY:
            begin
                st_pct = 8;
                fi_pct = 30;
            end
            CODE_CLOSING:
            begin
                st_pct = 5;
                fi_pct = 10;
            end
            default:
            begin
                st_pct = 20;
                fi_pct = 20;
            end
        endcase
        if (gs_phase == CODE_AUTH)
        begin
            r = $urandom_range(0, 99);
            if (r < 45)
                e = AUTH_NONE;
            else if (r < 75)
                e = AUTH_GRANT;
            else if (r < 90)
                e = AUTH_REJECT;
            else
                e = AUTH_UNUSED;
        end
        if ($urandom_range(0, 9) == 0)
        begin
            st_pct = 50;
            fi_pct = 50;
        end
        st = ($urandom_range(0, 99) < st_pct);
        fi = ($urandom_range(0, 99) < fi_pct);
        o = gs_exit ? fi : st;
        i = gs_exit ? st : fi;
    endtask

    function automatic step_row_t tick_row(bit o, bit i, logic [1:0] e);
        step_row_t row;
        row = '{default: '0};
        row.outer = o;
        row.inner = i;
        row.ev = e;
        return row;
    endfunction

    function automatic step_row_t typed_row(bit o, bit i, logic [1:0] e, result_t want);
        step_row_t row;
        row = tick_row(o, i, e);
        row.typed = 1'b1;
        row.want = want;
        return row;
    endfunction

    function automatic step_row_t cfg_row(logic [CFG_INDEX_W-1:0] idx,
                                          logic [CFG_DATA_W-1:0] data);
        step_row_t row;
        row = '{default: '0};
        row.is_cfg = 1'b1;
        row.idx = idx;
        row.data = data;
        return row;
    endfunction

    initial
    begin
        step_row_t    plan[$];
        cfg_profile_t sched[9];
        logic [17:0]  v_step, v_angle, v_clear, v_timeout, v_refuse, v_blink;
        int           items;
        bit           o;
        bit           i;
        logic [1:0]   e;

        sched = '{SET_SMALL, SET_SMALL, SET_MAXED, SET_SMALL, SET_WIDE,
                  SET_MINIMAL, SET_SMALL, SET_ONES, SET_SMALL};

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        plan.push_back(typed_row(0, 0, AUTH_NONE,
            result_t'{CODE_IDLE, 8'd0, LED_RED, 1'b0, 1'b0, REP_NONE, 1'b1}));
        plan.push_back(cfg_row(CFG_STEP_TICKS, 18'd1));
        plan.push_back(cfg_row(CFG_OPEN_ANGLE, 18'd2));
        plan.push_back(cfg_row(CFG_CLEAR_WAIT, 18'd1));
        plan.push_back(cfg_row(CFG_AUTH_TIMEOUT, 18'd2));
        plan.push_back(cfg_row(CFG_REFUSE_HOLD, 18'd0));
        plan.push_back(cfg_row(CFG_BLINK_TICKS, 18'd1));
        plan.push_back(cfg_row(CFG_NO_REG_6, '1));
        plan.push_back(cfg_row(CFG_NO_REG_7, '0));
        plan.push_back(typed_row(1, 0, AUTH_NONE,
            result_t'{CODE_AUTH, 8'd0, LED_YELLOW, 1'b0, 1'b1, REP_NONE, 1'b1}));
        plan.push_back(typed_row(0, 0, AUTH_REJECT,
            result_t'{CODE_REFUSED, 8'd0, LED_RED, 1'b0, 1'b0, REP_CLOSED, 1'b1}));
        plan.push_back(typed_row(0, 0, AUTH_NONE,
            result_t'{CODE_IDLE, 8'd0, LED_RED, 1'b0, 1'b0, REP_NONE, 1'b1}));
        plan.push_back(typed_row(0, 1, AUTH_NONE,
            result_t'{CODE_AUTH, 8'd0, LED_YELLOW, 1'b1, 1'b1, REP_NONE, 1'b1}));
        plan.push_back(tick_row(0, 0, AUTH_NONE));
        plan.push_back(typed_row(0, 0, AUTH_UNUSED,
            result_t'{CODE_REFUSED, 8'd0, LED_RED, 1'b1, 1'b0, REP_CLOSED, 1'b1}));
        plan.push_back(tick_row(0, 0, AUTH_NONE));
        plan.push_back(tick_row(1, 1, AUTH_GRANT));
        plan.push_back(tick_row(0, 0, AUTH_GRANT));
        plan.push_back(tick_row(0, 1, AUTH_NONE));
        plan.push_back(tick_row(0, 0, AUTH_NONE));
        plan.push_back(tick_row(1, 0, AUTH_NONE));
        plan.push_back(tick_row(0, 1, AUTH_NONE));
        plan.push_back(tick_row(0, 1, AUTH_NONE));
        plan.push_back(tick_row(0, 0, AUTH_NONE));
        plan.push_back(tick_row(1, 0, AUTH_NONE));
        plan.push_back(tick_row(0, 0, AUTH_NONE));
        plan.push_back(tick_row(0, 1, AUTH_NONE));
        plan.push_back(tick_row(0, 0, AUTH_NONE));
        plan.push_back(tick_row(0, 0, AUTH_NONE));
        plan.push_back(tick_row(0, 0, AUTH_NONE));
        plan.push_back(cfg_row(CFG_STEP_TICKS, 18'd0));
        plan.push_back(cfg_row(CFG_OPEN_ANGLE, 18'd200));
        plan.push_back(cfg_row(CFG_CLEAR_WAIT, 18'd0));
        plan.push_back(cfg_row(CFG_AUTH_TIMEOUT, 18'd0));
        plan.push_back(cfg_row(CFG_BLINK_TICKS, 18'd0));
        plan.push_back(tick_row(0, 1, AUTH_NONE));
        plan.push_back(tick_row(0, 0, AUTH_GRANT));
        plan.push_back(tick_row(0, 0, AUTH_NONE));
        plan.push_back(tick_row(0, 0, AUTH_NONE));
        plan.push_back(cfg_row(CFG_OPEN_ANGLE, 18'd1));
        plan.push_back(tick_row(0, 0, AUTH_NONE));

        foreach (plan[k])
        begin
            if (plan[k].is_cfg)
                cfg_write(plan[k].idx, plan[k].data);
            else
                send_tick(plan[k].outer, plan[k].inner, plan[k].ev,
                          plan[k].typed, plan[k].want);
        end

        foreach (sched[r])
        begin
            items = 110;
            case (sched[r])
                SET_SMALL:
                begin
                    v_step = 18'($urandom_range(1, 3));
                    v_angle = 18'($urandom_range(1, 8));
                    v_clear = 18'($urandom_range(0, 12));
                    v_timeout = 18'($urandom_range(1, 40));
                    v_refuse = 18'($urandom_range(0, 10));
                    v_blink = 18'($urandom_range(1, 5));
                    items = 220;
                end
                SET_MAXED:
                begin
                    v_step = 18'd255;
                    v_angle = 18'd255;
                    v_clear = 18'd65535;
                    v_timeout = 18'd262143;
                    v_refuse = 18'd65535;
                    v_blink = 18'd1023;
                end
                SET_WIDE:
                begin
                    v_step = 18'($urandom_range(0, 18'h3FFFF));
                    v_angle = 18'($urandom_range(0, 18'h3FFFF));
                    v_clear = 18'($urandom_range(0, 18'h3FFFF));
                    v_timeout = 18'($urandom_range(0, 18'h3FFFF));
                    v_refuse = 18'($urandom_range(0, 18'h3FFFF));
                    v_blink = 18'($urandom_range(0, 18'h3FFFF));
                end
                SET_MINIMAL:
                begin
                    v_step = '0;
                    v_angle = '0;
                    v_clear = '0;
                    v_timeout = '0;
                    v_refuse = '0;
                    v_blink = '0;
                end
                default:
                begin
                    v_step = 18'd1;
                    v_angle = 18'd1;
                    v_clear = 18'd1;
                    v_timeout = 18'd1;
                    v_refuse = 18'd1;
                    v_blink = 18'd1;
                end
            endcase
            cfg_write(CFG_STEP_TICKS, v_step);
            cfg_write(CFG_OPEN_ANGLE, v_angle);
            cfg_write(CFG_CLEAR_WAIT, v_clear);
            cfg_write(CFG_AUTH_TIMEOUT, v_timeout);
            cfg_write(CFG_REFUSE_HOLD, v_refuse);
            cfg_write(CFG_BLINK_TICKS, v_blink);
            // hold off the result side long enough to back up the tick side
            if (r == 1)
                rx_hold = 400;
            for (int n = 0; n < items; n++)
            begin
                if (n % 50 == 0)
                begin
                    tx_gaps = ($urandom_range(0, 3) != 0);
                    rx_gaps = ($urandom_range(0, 3) != 0);
                end
                draw_tick(o, i, e);
                send_tick(o, i, e, 1'b0, '0);
            end
        end

        in_valid <= 1'b0;
        while (gate_snapshots.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0 && gate_snapshots.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        int      n;
        result_t got;
        result_t want;
        wait (rst_n === 1'b1);
        forever
        begin
            n = rx_gaps ? $urandom_range(0, 6) : 0;
            if (rx_hold != 0)
            begin
                n = rx_hold;
                rx_hold = 0;
            end
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
                out_stall <= 1'b0;
            end
            @(posedge clk);
            while (out_valid !== 1'b1)
                @(posedge clk);
            got = {gate_phase, servo_angle, led_color, travel_exit,
                   auth_wanted, status_report, last_of_run};
            if (gate_snapshots.size() == 0)
            begin
                if (fail_count < 10)
                    $display("unexpected result at %0t: phase %0d angle %0d report %0d",
                             $time, got.gate_phase, got.servo_angle, got.status_report);
                fail_count++;
            end
            else
            begin
                want = gate_snapshots.pop_front();
                if (got !== want)
                begin
                    if (fail_count < 10)
                        $display("mismatch at %0t: expected phase %0d angle %0d led %0d ",
                                 $time, want.gate_phase, want.servo_angle, want.led_color,
                                 "exit %0d wanted %0d report %0d last %0d; ",
                                 want.travel_exit, want.auth_wanted, want.status_report,
                                 want.last_of_run,
                                 "got phase %0d angle %0d led %0d exit %0d ",
                                 got.gate_phase, got.servo_angle, got.led_color,
                                 got.travel_exit,
                                 "wanted %0d report %0d last %0d",
                                 got.auth_wanted, got.status_report, got.last_of_run);
                    fail_count++;
                end
            end
        end
    end

endmodule
